>>> src/blepdu_pkg.sv
// shared constants, types and field codes of the advertising pdu parser
`timescale 1ns / 1ps
`default_nettype none
package blepdu_pkg;

	// capture store and length limits
	localparam int STORE_DEPTH      = 36;
	localparam int MAX_PACKET_BYTES = 64;
	localparam int COUNT_W          = 7;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

	// results per packet index (status plus up to twelve fields)
	localparam int RES_IDX_W = 4;

	// queue between capture and result sequencing, depth a power of two
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = 1;
	localparam int FIFO_CNT_W = 2;

	// advertising pdu type codes
	localparam logic [3:0] PDU_ADV_IND         = 4'd0;
	localparam logic [3:0] PDU_ADV_DIRECT_IND  = 4'd1;
	localparam logic [3:0] PDU_ADV_NONCONN_IND = 4'd2;
	localparam logic [3:0] PDU_SCAN_REQ        = 4'd3;
	localparam logic [3:0] PDU_SCAN_RSP        = 4'd4;
	localparam logic [3:0] PDU_CONNECT_REQ     = 4'd5;
	localparam logic [3:0] PDU_ADV_SCAN_IND    = 4'd6;

	// payload length rules
	localparam logic [5:0] LEN_ADDR_MIN  = 6'd6;
	localparam logic [5:0] LEN_TWO_ADDR  = 6'd12;
	localparam logic [5:0] LEN_CONNECT   = 6'd34;

	// last result index per packet kind
	localparam logic [RES_IDX_W-1:0] LAST_IDX_STATUS  = 4'd0;
	localparam logic [RES_IDX_W-1:0] LAST_IDX_TWO     = 4'd2;
	localparam logic [RES_IDX_W-1:0] LAST_IDX_CONNECT = 4'd12;

	// field identifiers
	localparam logic [3:0] FID_STATUS     = 4'd0;
	localparam logic [3:0] FID_ADV_ADDR   = 4'd1;
	localparam logic [3:0] FID_INIT_ADDR  = 4'd2;
	localparam logic [3:0] FID_SCAN_ADDR  = 4'd3;
	localparam logic [3:0] FID_DATA_LEN   = 4'd4;
	localparam logic [3:0] FID_ACC_ADDR   = 4'd5;
	localparam logic [3:0] FID_CRC_INIT   = 4'd6;
	localparam logic [3:0] FID_WIN_SIZE   = 4'd7;
	localparam logic [3:0] FID_WIN_OFFSET = 4'd8;
	localparam logic [3:0] FID_INTERVAL   = 4'd9;
	localparam logic [3:0] FID_LATENCY    = 4'd10;
	localparam logic [3:0] FID_TIMEOUT    = 4'd11;
	localparam logic [3:0] FID_CHAN_MAP   = 4'd12;
	localparam logic [3:0] FID_HOP        = 4'd13;
	localparam logic [3:0] FID_SCA        = 4'd14;

	typedef logic [STORE_DEPTH-1:0][7:0] store_t;

	typedef struct packed {
		logic [7:0] pkt_byte;
		logic       last;
	} pkt_in_t;

	typedef struct packed {
		logic [3:0]  field_id;
		logic [47:0] field_value;
		logic        valid_res;
		logic [3:0]  adv_type;
		logic        tx_add;
		logic        rx_add;
		logic [5:0]  adv_length;
		logic        last_result;
	} pkt_res_t;

	// one classified packet waiting for result sequencing
	typedef struct packed {
		store_t                 bytes;
		logic                   valid;
		logic [RES_IDX_W-1:0]   last_idx;
	} pkt_entry_t;

endpackage
`default_nettype wire

>>> src/blepdu_front.sv
// byte capture and packet classification
`timescale 1ns / 1ps
`default_nettype none
module blepdu_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  byte_valid,
	output logic                       byte_stall,
	input  wire blepdu_pkg::pkt_in_t   byte_data,
	output logic                       push,
	output blepdu_pkg::pkt_entry_t     push_entry,
	input  wire logic                  fifo_full
);

	blepdu_pkg::store_t                   store_q;
	blepdu_pkg::store_t                   store_nxt;
	logic [blepdu_pkg::COUNT_W-1:0]       cnt_q;
	logic [blepdu_pkg::COUNT_W-1:0]       cnt_nxt;
	logic                                 in_packet_q;
	logic                                 accept;
	logic [5:0]                           len;
	logic [3:0]                           ptype;
	logic                                 size_ok;
	logic                                 valid;

	// only a closing byte needs a queue slot
	assign byte_stall = byte_data.last & fifo_full;
	assign accept     = byte_valid & ~byte_stall;
	assign push       = accept & byte_data.last;

	// store contents including the byte now being taken
	always_comb begin
		for (int i = 0; i < blepdu_pkg::STORE_DEPTH; i++) begin
			if (!in_packet_q) begin
				store_nxt[i] = (i == 0) ? byte_data.pkt_byte : 8'h00;
			end else if (cnt_q == blepdu_pkg::COUNT_W'(i)) begin
				store_nxt[i] = byte_data.pkt_byte;
			end else begin
				store_nxt[i] = store_q[i];
			end
		end
	end

	always_comb begin
		if (!in_packet_q) begin
			cnt_nxt = blepdu_pkg::COUNT_W'(1);
		end else if (cnt_q == blepdu_pkg::COUNT_MAX) begin
			cnt_nxt = cnt_q;
		end else begin
			cnt_nxt = cnt_q + blepdu_pkg::COUNT_W'(1);
		end
	end

	assign len   = store_nxt[1][5:0];
	assign ptype = store_nxt[0][3:0];
	assign size_ok = (cnt_nxt >= blepdu_pkg::COUNT_W'(2))
		&& ({1'b0, cnt_nxt} <= 8'(blepdu_pkg::MAX_PACKET_BYTES))
		&& ({1'b0, len} <= cnt_nxt);

	always_comb begin
		unique case (ptype) inside
			blepdu_pkg::PDU_ADV_IND, blepdu_pkg::PDU_ADV_NONCONN_IND,
			blepdu_pkg::PDU_SCAN_RSP, blepdu_pkg::PDU_ADV_SCAN_IND: begin
				valid = size_ok && (len >= blepdu_pkg::LEN_ADDR_MIN);
			end
			blepdu_pkg::PDU_ADV_DIRECT_IND, blepdu_pkg::PDU_SCAN_REQ: begin
				valid = size_ok && (len == blepdu_pkg::LEN_TWO_ADDR);
			end
			blepdu_pkg::PDU_CONNECT_REQ: begin
				valid = size_ok && (len == blepdu_pkg::LEN_CONNECT);
			end
			default: begin
				valid = 1'b0;
			end
		endcase
	end

	always_comb begin
		push_entry.bytes = store_nxt;
		push_entry.valid = valid;
		if (!valid) begin
			push_entry.last_idx = blepdu_pkg::LAST_IDX_STATUS;
		end else if (ptype == blepdu_pkg::PDU_CONNECT_REQ) begin
			push_entry.last_idx = blepdu_pkg::LAST_IDX_CONNECT;
		end else begin
			push_entry.last_idx = blepdu_pkg::LAST_IDX_TWO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			in_packet_q <= 1'b0;
		end else if (accept) begin
			cnt_q       <= cnt_nxt;
			in_packet_q <= ~byte_data.last;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			store_q <= store_nxt;
		end
	end

endmodule
`default_nettype wire

>>> src/blepdu_fifo.sv
// short queue of classified packets
`timescale 1ns / 1ps
`default_nettype none
module blepdu_fifo (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire blepdu_pkg::pkt_entry_t  push_entry,
	output logic                         full,
	input  wire logic                    pop,
	output logic                         head_valid,
	output blepdu_pkg::pkt_entry_t       head
);

	blepdu_pkg::pkt_entry_t              mem_q [blepdu_pkg::FIFO_DEPTH];
	logic [blepdu_pkg::FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [blepdu_pkg::FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [blepdu_pkg::FIFO_CNT_W-1:0]   cnt_q;
	logic                                do_push;
	logic                                do_pop;

	assign full       = (cnt_q == blepdu_pkg::FIFO_CNT_W'(blepdu_pkg::FIFO_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push & ~full;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + blepdu_pkg::FIFO_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + blepdu_pkg::FIFO_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + blepdu_pkg::FIFO_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - blepdu_pkg::FIFO_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// occupancy never passes the depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= blepdu_pkg::FIFO_CNT_W'(blepdu_pkg::FIFO_DEPTH))
		else $error("queue count beyond depth");

endmodule
`default_nettype wire

>>> src/blepdu_back.sv
// result sequencing and output register
`timescale 1ns / 1ps
`default_nettype none
module blepdu_back (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    head_valid,
	input  wire blepdu_pkg::pkt_entry_t  head,
	output logic                         pop,
	output logic                         res_valid,
	input  wire logic                    res_stall,
	output blepdu_pkg::pkt_res_t         res_data
);

	logic [blepdu_pkg::RES_IDX_W-1:0]    k_q;
	logic                                out_valid_q;
	blepdu_pkg::pkt_res_t                out_q;
	blepdu_pkg::pkt_res_t                res_nxt;
	blepdu_pkg::store_t                  s;
	logic                                advance;
	logic                                is_last;
	logic [3:0]                          fid;
	logic [47:0]                         fval;

	assign s       = head.bytes;
	assign advance = ~out_valid_q | ~res_stall;
	assign is_last = (k_q == head.last_idx);
	assign pop     = advance & head_valid & is_last;

	// field selection by pdu type and result index
	always_comb begin
		fid  = blepdu_pkg::FID_STATUS;
		fval = '0;
		if (k_q != '0) begin
			unique case (s[0][3:0]) inside
				blepdu_pkg::PDU_ADV_IND, blepdu_pkg::PDU_ADV_NONCONN_IND,
				blepdu_pkg::PDU_SCAN_RSP, blepdu_pkg::PDU_ADV_SCAN_IND: begin
					if (k_q == 4'd1) begin
						fid  = blepdu_pkg::FID_ADV_ADDR;
						fval = {s[7], s[6], s[5], s[4], s[3], s[2]};
					end else begin
						fid  = blepdu_pkg::FID_DATA_LEN;
						fval = {42'h0, s[1][5:0] - blepdu_pkg::LEN_ADDR_MIN};
					end
				end
				blepdu_pkg::PDU_ADV_DIRECT_IND: begin
					if (k_q == 4'd1) begin
						fid  = blepdu_pkg::FID_ADV_ADDR;
						fval = {s[7], s[6], s[5], s[4], s[3], s[2]};
					end else begin
						fid  = blepdu_pkg::FID_INIT_ADDR;
						fval = {s[13], s[12], s[11], s[10], s[9], s[8]};
					end
				end
				blepdu_pkg::PDU_SCAN_REQ: begin
					if (k_q == 4'd1) begin
						fid  = blepdu_pkg::FID_SCAN_ADDR;
						fval = {s[7], s[6], s[5], s[4], s[3], s[2]};
					end else begin
						fid  = blepdu_pkg::FID_ADV_ADDR;
						fval = {s[13], s[12], s[11], s[10], s[9], s[8]};
					end
				end
				blepdu_pkg::PDU_CONNECT_REQ: begin
					case (k_q)
						4'd1: begin
							fid  = blepdu_pkg::FID_INIT_ADDR;
							fval = {s[7], s[6], s[5], s[4], s[3], s[2]};
						end
						4'd2: begin
							fid  = blepdu_pkg::FID_ADV_ADDR;
							fval = {s[13], s[12], s[11], s[10], s[9], s[8]};
						end
						4'd3: begin
							fid  = blepdu_pkg::FID_ACC_ADDR;
							fval = {16'h0, s[17], s[16], s[15], s[14]};
						end
						4'd4: begin
							fid  = blepdu_pkg::FID_CRC_INIT;
							fval = {24'h0, s[20], s[19], s[18]};
						end
						4'd5: begin
							fid  = blepdu_pkg::FID_WIN_SIZE;
							fval = {40'h0, s[21]};
						end
						4'd6: begin
							fid  = blepdu_pkg::FID_WIN_OFFSET;
							fval = {32'h0, s[23], s[22]};
						end
						4'd7: begin
							fid  = blepdu_pkg::FID_INTERVAL;
							fval = {32'h0, s[25], s[24]};
						end
						4'd8: begin
							fid  = blepdu_pkg::FID_LATENCY;
							fval = {32'h0, s[27], s[26]};
						end
						4'd9: begin
							fid  = blepdu_pkg::FID_TIMEOUT;
							fval = {32'h0, s[29], s[28]};
						end
						4'd10: begin
							fid  = blepdu_pkg::FID_CHAN_MAP;
							fval = {8'h0, s[34], s[33], s[32], s[31], s[30]};
						end
						4'd11: begin
							fid  = blepdu_pkg::FID_HOP;
							fval = {43'h0, s[35][4:0]};
						end
						default: begin
							fid  = blepdu_pkg::FID_SCA;
							fval = {45'h0, s[35][7:5]};
						end
					endcase
				end
				default: begin
					fid  = blepdu_pkg::FID_STATUS;
					fval = '0;
				end
			endcase
		end
	end

	always_comb begin
		res_nxt.field_id    = fid;
		res_nxt.field_value = fval;
		res_nxt.valid_res   = head.valid;
		res_nxt.adv_type    = s[0][3:0];
		res_nxt.tx_add      = s[0][6];
		res_nxt.rx_add      = s[0][7];
		res_nxt.adv_length  = s[1][5:0];
		res_nxt.last_result = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				k_q <= is_last ? '0 : k_q + blepdu_pkg::RES_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && head_valid) begin
			out_q <= res_nxt;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	// mid-packet index only while that packet heads the queue
	a_idx_head: assert property (@(posedge clk) disable iff (!arst_n)
		(k_q != '0) |-> head_valid)
		else $error("result index set with empty queue");

	// index never runs past the packet's last result
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (k_q <= head.last_idx))
		else $error("result index past last result");

	// a rejected packet yields its status result alone
	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.valid_res) |->
		(out_q.last_result && out_q.field_id == blepdu_pkg::FID_STATUS))
		else $error("invalid packet produced field results");

endmodule
`default_nettype wire

>>> src/ble_adv_pdu_parser_unit.sv
// top level of the advertising channel pdu parser
//
//  channel | role   | payload type           | control
//  --------+--------+------------------------+----------------------
//  byte    | sink   | blepdu_pkg::pkt_in_t   | byte_valid, byte_stall
//  res     | source | blepdu_pkg::pkt_res_t  | res_valid, res_stall
//
// one byte request is taken per cycle unless stalled; bytes go into a 36-byte store
// the closing byte classifies the packet and queues it (two packets deep)
// results leave one per cycle unless stalled: 1 for a rejected packet,
// 3 for most types, 13 for a connect request, as the sequencer walks the fields
// byte_stall rises only for a closing byte while the queue is full
// reset clears counters, queue pointers and the output valid; the store needs none
`timescale 1ns / 1ps
`default_nettype none
module ble_adv_pdu_parser_unit (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  byte_valid,
	output logic                       byte_stall,
	input  wire blepdu_pkg::pkt_in_t   byte_data,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output blepdu_pkg::pkt_res_t       res_data
);

	// front to queue
	logic                        push;
	blepdu_pkg::pkt_entry_t      push_entry;
	logic                        fifo_full;

	// queue to back
	logic                        pop;
	logic                        head_valid;
	blepdu_pkg::pkt_entry_t      head;

	// capture bytes, check lengths and type rule on the closing byte
	blepdu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.push       (push),
		.push_entry (push_entry),
		.fifo_full  (fifo_full)
	);

	// decouples byte capture from result draining
	blepdu_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (fifo_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// walk the head packet's fields into the output register
	blepdu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

endmodule
`default_nettype wire

>>> test/tb_ble_adv_pdu_parser_unit.sv
// testbench of the advertising channel pdu parser: directed table and random packets
`timescale 1ns / 1ps
module tb_ble_adv_pdu_parser_unit;
	import blepdu_pkg::*;

	localparam int GAP_MAX      = 10;
	localparam int HOLD_CYCLES  = 400;   // one long receiver hold-off
	localparam int IDLE_LIMIT   = 5000;  // cycles with no request or result taken
	localparam int DRAIN_CYCLES = 64;
	localparam int RAND_BYTES   = 40;

	typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_e;

	// one directed packet; the status fields are typed in only where pinned
	typedef struct {
		logic [7:0] h0;
		logic [7:0] h1;
		int         nbytes;
		fill_e      fill;
		bit         pin;
		logic       exp_valid;
		logic [3:0] exp_type;
		logic [5:0] exp_len;
	} pdu_case_t;

	typedef struct {
		bit       en;
		pkt_res_t st;
	} status_pin_t;

	logic     clk;
	logic     arst_n     = 1'b0;
	logic     byte_valid = 1'b0;
	logic     byte_stall;
	pkt_in_t  byte_data  = '0;
	logic     res_valid;
	logic     res_stall  = 1'b0;
	pkt_res_t res_data;

	ble_adv_pdu_parser_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

	// own copy of the capture state
	logic [COUNT_W-1:0] seen_cnt = '0;
	logic [7:0]         cap_store [STORE_DEPTH];
	bit                 in_pdu = 1'b0;

	pkt_res_t    pending_fields [$];   // expected results, oldest first
	status_pin_t status_pins [$];      // one entry per packet sent, in order
	int          errors      = 0;
	int          idle_cycles = 0;
	bit          hold_req    = 1'b0;

	// directed packets: extremes, the address types and each corner of the checks
	pdu_case_t dir_cases [9] = '{
		// lone header byte, length reads as zero
		'{8'h40, 8'h00,   1, FILL_RAND, 1'b1, 1'b0, 4'd0,  6'd0},
		// two bytes, payload too short for an address
		'{8'hC0, 8'h00,   2, FILL_RAND, 1'b1, 1'b0, 4'd0,  6'd0},
		'{8'h00, 8'h06,   8, FILL_ONES, 1'b0, 1'b0, 4'd0,  6'd0},
		'{8'h01, 8'h0C,  14, FILL_RAND, 1'b0, 1'b0, 4'd0,  6'd0},
		'{8'h43, 8'h0C,  14, FILL_ONES, 1'b0, 1'b0, 4'd0,  6'd0},
		// connect request with every field at its maximum
		'{8'hC5, 8'h22,  36, FILL_ONES, 1'b0, 1'b0, 4'd0,  6'd0},
		// reserved type
		'{8'h07, 8'h06,   8, FILL_RAND, 1'b1, 1'b0, 4'd7,  6'd6},
		// length field beyond the byte count
		'{8'h0F, 8'hFF,   8, FILL_RAND, 1'b1, 1'b0, 4'd15, 6'd63},
		// one byte over the maximum packet, bytes past the store dropped
		'{8'h00, 8'h06,  65, FILL_RAND, 1'b1, 1'b0, 4'd0,  6'd6}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// little-endian read of captured bytes
	function automatic logic [47:0] le_bytes(int off, int n);
		logic [47:0] v = '0;
		for (int i = 0; i < n; i++)
			v[8*i +: 8] = cap_store[off + i];
		return v;
	endfunction

	// capture one request and, on a closing byte, queue the packet's results
	function automatic void capture_byte(pkt_in_t in);
		logic [5:0]  len;
		logic [3:0]  typ;
		logic        ok;
		logic [3:0]  ids [$];
		logic [47:0] vals [$];
		pkt_res_t    r;
		status_pin_t pin;
		if (!in_pdu) begin
			foreach (cap_store[i])
				cap_store[i] = '0;
			seen_cnt = '0;
			in_pdu   = 1'b1;
		end
		if (seen_cnt < STORE_DEPTH)
			cap_store[seen_cnt] = in.pkt_byte;
		if (seen_cnt < COUNT_MAX)
			seen_cnt++;
		if (!in.last)
			return;
		in_pdu = 1'b0;
		pin = '{en: 1'b0, st: '0};
		if (status_pins.size() != 0)
			pin = status_pins.pop_front();

		len = cap_store[1][5:0];
		typ = cap_store[0][3:0];
		ok  = seen_cnt >= 2 && seen_cnt <= MAX_PACKET_BYTES && len <= seen_cnt;
		case (typ)
			PDU_ADV_IND, PDU_ADV_NONCONN_IND, PDU_SCAN_RSP, PDU_ADV_SCAN_IND:
				ok = ok && len >= LEN_ADDR_MIN;
			PDU_ADV_DIRECT_IND, PDU_SCAN_REQ:
				ok = ok && len == LEN_TWO_ADDR;
			PDU_CONNECT_REQ:
				ok = ok && len == LEN_CONNECT;
			default:
				ok = 1'b0;
		endcase

		ids.push_back(FID_STATUS);
		vals.push_back('0);
		if (ok) begin
			case (typ)
				PDU_ADV_DIRECT_IND: begin
					ids.push_back(FID_ADV_ADDR);   vals.push_back(le_bytes(2, 6));
					ids.push_back(FID_INIT_ADDR);  vals.push_back(le_bytes(8, 6));
				end
				PDU_SCAN_REQ: begin
					ids.push_back(FID_SCAN_ADDR);  vals.push_back(le_bytes(2, 6));
					ids.push_back(FID_ADV_ADDR);   vals.push_back(le_bytes(8, 6));
				end
				PDU_CONNECT_REQ: begin
					ids.push_back(FID_INIT_ADDR);  vals.push_back(le_bytes(2, 6));
					ids.push_back(FID_ADV_ADDR);   vals.push_back(le_bytes(8, 6));
					ids.push_back(FID_ACC_ADDR);   vals.push_back(le_bytes(14, 4));
					ids.push_back(FID_CRC_INIT);   vals.push_back(le_bytes(18, 3));
					ids.push_back(FID_WIN_SIZE);   vals.push_back(le_bytes(21, 1));
					ids.push_back(FID_WIN_OFFSET); vals.push_back(le_bytes(22, 2));
					ids.push_back(FID_INTERVAL);   vals.push_back(le_bytes(24, 2));
					ids.push_back(FID_LATENCY);    vals.push_back(le_bytes(26, 2));
					ids.push_back(FID_TIMEOUT);    vals.push_back(le_bytes(28, 2));
					ids.push_back(FID_CHAN_MAP);   vals.push_back(le_bytes(30, 5));
					ids.push_back(FID_HOP);        vals.push_back(48'(cap_store[35][4:0]));
					ids.push_back(FID_SCA);        vals.push_back(48'(cap_store[35][7:5]));
				end
				default: begin
					ids.push_back(FID_ADV_ADDR);   vals.push_back(le_bytes(2, 6));
					ids.push_back(FID_DATA_LEN);   vals.push_back(48'(len - LEN_ADDR_MIN));
				end
			endcase
		end

		foreach (ids[k]) begin
			r.field_id    = ids[k];
			r.field_value = vals[k];
			r.valid_res   = ok;
			r.adv_type    = typ;
			r.tx_add      = cap_store[0][6];
			r.rx_add      = cap_store[0][7];
			r.adv_length  = len;
			r.last_result = (k == ids.size() - 1);
			// typed-in status replaces the computed one
			if (k == 0 && pin.en)
				r = pin.st;
			pending_fields.push_back(r);
		end
	endfunction

	task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// request and result monitor, plus the watchdog
	always @(posedge clk) begin : monitor
		pkt_res_t want;
		if (arst_n) begin
			// the byte first, so a result on the same edge finds its expectation
			if (byte_valid && !byte_stall)
				capture_byte(byte_data);
			if (res_valid && !res_stall) begin
				if (pending_fields.size() == 0) begin
					$error("result with nothing expected: field_id %0d", res_data.field_id);
					errors++;
				end else begin
					want = pending_fields.pop_front();
					check_field("field_id",    want.field_id,    res_data.field_id);
					check_field("field_value", want.field_value, res_data.field_value);
					check_field("valid_res",   want.valid_res,   res_data.valid_res);
					check_field("adv_type",    want.adv_type,    res_data.adv_type);
					check_field("tx_add",      want.tx_add,      res_data.tx_add);
					check_field("rx_add",      want.rx_add,      res_data.rx_add);
					check_field("adv_length",  want.adv_length,  res_data.adv_length);
					check_field("last_result", want.last_result, res_data.last_result);
				end
			end
			if ((byte_valid && !byte_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("ble_adv_pdu_parser_unit test failed");
				$finish;
			end
		end
	end

	// offer one byte request after a random gap and wait until it is taken
	task automatic push_byte(logic [7:0] b, logic l, bit quiet);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= '{pkt_byte: b, last: l};
		@(posedge clk);
		while (byte_stall) @(posedge clk);
	endtask

	task automatic send_pdu(logic [7:0] h0, logic [7:0] h1, int nbytes, fill_e fill,
			bit pin, pkt_res_t pin_st);
		bit         quiet;
		logic [7:0] b;
		// some packets go back to back with no gaps at all
		quiet = ($urandom_range(0, 3) == 0);
		status_pins.push_back('{en: pin, st: pin_st});
		for (int i = 0; i < nbytes; i++) begin
			if (i == 0)
				b = h0;
			else if (i == 1)
				b = h1;
			else if (fill == FILL_ZERO)
				b = 8'h00;
			else if (fill == FILL_ONES)
				b = 8'hFF;
			else
				b = 8'($urandom);
			push_byte(b, i == nbytes - 1, quiet);
		end
	endtask

	// result side: random stall per result, one long hold-off on request
	initial begin : result_side
		int n;
		int served;
		bit quiet;
		served = 0;
		quiet  = 1'b0;
		wait (arst_n);
		forever begin
			if (served % 16 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (hold_req) begin
				hold_req = 1'b0;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			n = quiet ? 0 : $urandom_range(0, GAP_MAX);
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
			served++;
		end
	end

	initial begin : stimulus
		pdu_case_t   row;
		pkt_res_t    pin_st;
		logic [7:0]  h0;
		logic [7:0]  h1;
		logic [3:0]  typ;
		logic [5:0]  len;
		int          nbytes;
		int          rand_bytes;

		// the receiver holds off from reset on, so the short first packets fill the queue
		hold_req = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_cases[i]) begin
			row = dir_cases[i];
			pin_st = '{field_id: FID_STATUS, field_value: '0, valid_res: row.exp_valid,
				adv_type: row.exp_type, tx_add: row.h0[6], rx_add: row.h0[7],
				adv_length: row.exp_len, last_result: !row.exp_valid};
			send_pdu(row.h0, row.h1, row.nbytes, row.fill, row.pin, pin_st);
		end

		// random packets
		rand_bytes = 0;
		while (rand_bytes < RAND_BYTES) begin
			if ($urandom_range(0, 9) < 7) begin
				// well-formed header and length, random content
				typ = 4'($urandom_range(0, 6));
				case (typ)
					PDU_ADV_DIRECT_IND, PDU_SCAN_REQ:
						len = LEN_TWO_ADDR;
					PDU_CONNECT_REQ:
						len = LEN_CONNECT;
					default:
						len = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(6, 63))
							: 6'($urandom_range(6, 16));
				endcase
				nbytes = len + $urandom_range(0, 2);
				if (nbytes > MAX_PACKET_BYTES)
					nbytes = MAX_PACKET_BYTES;
				h0 = {4'($urandom), typ};
				h1 = {2'($urandom), len};
			end else begin
				// noise: any header, any size, now and then past the store or the maximum
				h0 = 8'($urandom);
				h1 = 8'($urandom);
				nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(36, 70)
					: $urandom_range(1, 16);
			end
			send_pdu(h0, h1, nbytes, FILL_RAND, 1'b0, '0);
			rand_bytes += nbytes;
		end
		byte_valid <= 1'b0;

		// let the last closing byte reach the predictor, then drain
		@(posedge clk);
		while (pending_fields.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("ble_adv_pdu_parser_unit test passed");
		else
			$display("ble_adv_pdu_parser_unit test failed");
		$finish;
	end

endmodule
